### design/xacs_pkg.sv
// ----------------------------------------------------------------------------
// xacs_pkg
// Shared widths, segment bounds and fit coefficient tables for the X-ray
// photoelectric absorption cross section pipeline.
// ----------------------------------------------------------------------------
package xacs_pkg;

	localparam int EW               = 14;  // energy in eV
	localparam int OUT_W            = 40;  // cross section result / quotient bits
	localparam int SEGW             = 4;
	localparam int SEGMENT_COUNT    = 14;
	localparam int RESULT_FRAC_BITS_DEF = 18;

	localparam int NW  = 48;  // clamped numerator, unsigned
	localparam int DW  = 47;  // denominator 100*e^3
	localparam int K0W = 48;
	localparam int K1W = 37;
	localparam int K2W = 29;
	localparam int PW  = 46;  // kept width of the signed products

	localparam int FRONT_STAGES = 4;

	localparam logic [EW-1:0] E_MIN_EV = 14'd30;
	localparam logic [EW-1:0] E_MAX_EV = 14'd10000;

	// lower bound of each segment, eV
	localparam logic [EW-1:0] SEG_LO [SEGMENT_COUNT] = '{
		14'd30,   14'd100,  14'd284,  14'd400,  14'd532,  14'd707,  14'd867,
		14'd1303, 14'd1840, 14'd2471, 14'd3210, 14'd4038, 14'd7111, 14'd8331
	};

	// c0*100*1e9
	localparam logic signed [K0W-1:0] K0_TAB [SEGMENT_COUNT] = '{
		48'sd1730000000000,  48'sd3460000000000,  48'sd7810000000000,
		48'sd7140000000000,  48'sd9550000000000,  48'sd30890000000000,
		48'sd12060000000000, 48'sd14130000000000, 48'sd20270000000000,
		48'sd34270000000000, 48'sd35220000000000, 48'sd43390000000000,
		48'sd62900000000000, 48'sd70120000000000
	};

	// c1*100*1e6
	localparam logic signed [K1W-1:0] K1_TAB [SEGMENT_COUNT] = '{
		37'sd60810000000,  37'sd26790000000,  37'sd1880000000,
		37'sd6680000000,   37'sd14580000000,  -37'sd38060000000,
		37'sd16930000000,  37'sd14680000000,  37'sd10470000000,
		37'sd1870000000,   37'sd1870000000,   -37'sd240000000,
		37'sd3090000000,   37'sd2520000000
	};

	// c2*100*1e3
	localparam logic signed [K2W-1:0] K2_TAB [SEGMENT_COUNT] = '{
		-29'sd215000000, -29'sd47610000, 29'sd430000,    -29'sd5140000,
		-29'sd6110000,   29'sd29400000,  -29'sd4770000,  -29'sd3150000,
		-29'sd1700000,   29'sd0,         29'sd0,         29'sd75000,
		29'sd0,          29'sd0
	};

	typedef struct packed {
		logic            oor;
		logic            sat;
		logic [SEGW-1:0] seg;
	} xacs_tag_t;

endpackage

### design/xacs_front.sv
// ----------------------------------------------------------------------------
// xacs_front
// Four-stage front end: segment search, coefficient lookup and products,
// numerator sum with clamp, and the 100*e^3 denominator.
// ----------------------------------------------------------------------------
module xacs_front
	import xacs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  logic [EW-1:0]   energy_in,
	output logic            valid_out,
	output logic [NW-1:0]   n_out,
	output logic [DW-1:0]   d_out,
	output xacs_tag_t       tag_out
);

	// stage 1: range check and segment search
	logic                  valid_s1;
	logic [EW-1:0]         e_s1;
	xacs_tag_t             tag_s1;
	xacs_tag_t             tag_d1;

	always_comb begin
		tag_d1     = '0;
		tag_d1.oor = (energy_in < E_MIN_EV) || (energy_in > E_MAX_EV);
		for (int i = 0; i < SEGMENT_COUNT; i++) begin
			if (energy_in >= SEG_LO[i]) begin
				tag_d1.seg = SEGW'(i);
			end
		end
		// top edge falls into the last segment by the search above
		if (tag_d1.oor) begin
			tag_d1.seg = '0;
		end
	end

	// stage 2: table read, e^2 and k1*e
	logic                   valid_s2;
	logic [EW-1:0]          e_s2;
	xacs_tag_t              tag_s2;
	logic [2*EW-1:0]        e2_s2;
	logic signed [PW-1:0]   p1_s2;
	logic signed [K0W-1:0]  k0_s2;
	logic signed [K2W-1:0]  k2_s2;
	logic signed [K1W+EW:0] p1_full;
	logic signed [K1W-1:0]  k1_rd;

	assign k1_rd   = K1_TAB[tag_s1.seg];
	assign p1_full = k1_rd * $signed({1'b0, e_s1});

	// stage 3: k2*e^2, e^3, k0 + k1*e
	logic                    valid_s3;
	xacs_tag_t               tag_s3;
	logic [OUT_W-1:0]        e3_s3;
	logic signed [K0W-1:0]   a_s3;
	logic signed [PW-1:0]    p2_s3;
	logic signed [2*K2W-1:0] p2_full;
	logic [3*EW-1:0]         e3_full;
	logic signed [K0W-1:0]   a_next;

	assign p2_full = k2_s2 * $signed({1'b0, e2_s2});
	assign e3_full = e2_s2 * e_s2;
	assign a_next  = k0_s2 + $signed({{(K0W-PW){p1_s2[PW-1]}}, p1_s2});

	// stage 4: numerator, clamp, denominator
	logic                valid_s4;
	xacs_tag_t           tag_s4;
	logic [NW-1:0]       n_s4;
	logic [DW-1:0]       d_s4;
	logic signed [NW:0]  n_sum;
	logic                n_pos;

	assign n_sum = $signed({a_s3[K0W-1], a_s3})
	             + $signed({{(NW+1-PW){p2_s3[PW-1]}}, p2_s3});
	assign n_pos = !n_sum[NW] && (n_sum != '0) && !tag_s3.oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		e_s1   <= energy_in;
		tag_s1 <= tag_d1;

		e_s2   <= e_s1;
		tag_s2 <= tag_s1;
		e2_s2  <= e_s1 * e_s1;
		p1_s2  <= $signed(p1_full[PW-1:0]);
		k0_s2  <= K0_TAB[tag_s1.seg];
		k2_s2  <= K2_TAB[tag_s1.seg];

		tag_s3 <= tag_s2;
		e3_s3  <= e3_full[OUT_W-1:0];
		a_s3   <= a_next;
		p2_s3  <= $signed(p2_full[PW-1:0]);

		tag_s4 <= tag_s3;
		n_s4   <= n_pos ? n_sum[NW-1:0] : '0;
		d_s4   <= DW'(e3_s3) * DW'(100);
	end

	assign valid_out = valid_s4;
	assign n_out     = n_s4;
	assign d_out     = d_s4;
	assign tag_out   = tag_s4;

endmodule

### design/xacs_div_stage.sv
// ----------------------------------------------------------------------------
// xacs_div_stage
// One restoring division step: brings in the next dividend bit, subtracts
// the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module xacs_div_stage
	import xacs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  logic [DW-1:0]    r_in,
	input  logic [OUT_W-1:0] l_in,
	input  logic [DW-1:0]    d_in,
	input  xacs_tag_t        tag_in,
	output logic             valid_out,
	output logic [DW-1:0]    r_out,
	output logic [OUT_W-1:0] l_out,
	output logic [DW-1:0]    d_out,
	output xacs_tag_t        tag_out
);

	logic             valid_s1;
	logic [DW-1:0]    r_s1;
	logic [OUT_W-1:0] l_s1;
	logic [DW-1:0]    d_s1;
	xacs_tag_t        tag_s1;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        fits;

	assign trial = {r_in, l_in[OUT_W-1]};
	assign diff  = trial - {1'b0, d_in};
	assign fits  = trial >= {1'b0, d_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= fits ? diff[DW-1:0] : trial[DW-1:0];
		l_s1   <= {l_in[OUT_W-2:0], fits};
		d_s1   <= d_in;
		tag_s1 <= tag_in;
	end

	assign valid_out = valid_s1;
	assign r_out     = r_s1;
	assign l_out     = l_s1;
	assign d_out     = d_s1;
	assign tag_out   = tag_s1;

endmodule

### design/xacs_divider.sv
// ----------------------------------------------------------------------------
// xacs_divider
// Pipelined fixed-point divider: floor(n * 2^FRAC_BITS / d), one quotient bit
// per stage, with an up-front overflow check against 2^OUT_W.
// ----------------------------------------------------------------------------
module xacs_divider
	import xacs_pkg::*;
#(
	parameter int FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  logic [NW-1:0]    n_in,
	input  logic [DW-1:0]    d_in,
	input  xacs_tag_t        tag_in,
	output logic             valid_out,
	output logic [OUT_W-1:0] q_out,
	output xacs_tag_t        tag_out
);

	localparam int XW = NW + FRAC_BITS;
	localparam int HW = XW - OUT_W;

	logic [XW-1:0] x;
	logic [HW-1:0] hi;
	xacs_tag_t     tag_d1;

	assign x  = {n_in, {FRAC_BITS{1'b0}}};
	assign hi = x[XW-1:OUT_W];

	// quotient needs more than OUT_W bits when the top part reaches d
	always_comb begin
		tag_d1     = tag_in;
		tag_d1.sat = !tag_in.oor && ((DW+1)'(hi) >= {1'b0, d_in});
	end

	logic             valid_s1;
	logic [DW-1:0]    r_s1;
	logic [OUT_W-1:0] l_s1;
	logic [DW-1:0]    d_s1;
	xacs_tag_t        tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= DW'(hi);
		l_s1   <= x[OUT_W-1:0];
		d_s1   <= d_in;
		tag_s1 <= tag_d1;
	end

	logic             v_c   [OUT_W+1];
	logic [DW-1:0]    r_c   [OUT_W+1];
	logic [OUT_W-1:0] l_c   [OUT_W+1];
	logic [DW-1:0]    d_c   [OUT_W+1];
	xacs_tag_t        tag_c [OUT_W+1];

	assign v_c[0]   = valid_s1;
	assign r_c[0]   = r_s1;
	assign l_c[0]   = l_s1;
	assign d_c[0]   = d_s1;
	assign tag_c[0] = tag_s1;

	for (genvar k = 0; k < OUT_W; k++) begin : g_step
		xacs_div_stage u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (v_c[k]),
			.r_in      (r_c[k]),
			.l_in      (l_c[k]),
			.d_in      (d_c[k]),
			.tag_in    (tag_c[k]),
			.valid_out (v_c[k+1]),
			.r_out     (r_c[k+1]),
			.l_out     (l_c[k+1]),
			.d_out     (d_c[k+1]),
			.tag_out   (tag_c[k+1])
		);
	end

	assign valid_out = v_c[OUT_W];
	assign q_out     = l_c[OUT_W];
	assign tag_out   = tag_c[OUT_W];

endmodule

### design/xray_absorption_cross_section.sv
// ----------------------------------------------------------------------------
// xray_absorption_cross_section
// Photoelectric absorption cross section over 30..10000 eV from a 14-segment
// quadratic fit divided by E^3, unsigned fixed point, saturating.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  -------   ------------   ------------------------------------------
//  request   start / busy   energy_ev[13:0]
//  result    valid strobe   cross_section[39:0], out_of_range, segment[3:0]
//
//  One transfer per cycle; busy stays low, so a request can follow every clock.
//  The pipeline has 4 front stages, 1 overflow-check stage, 40 divider
//  stages (one quotient bit each) and the output register.
//  The result strobe is high for one cycle per request; the receiver cannot
//  stall, so the pipeline never holds.
//  arst_n clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module xray_absorption_cross_section
	import xacs_pkg::*;
#(
	parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [EW-1:0]    energy_ev,
	output logic             valid,
	output logic [OUT_W-1:0] cross_section,
	output logic             out_of_range,
	output logic [SEGW-1:0]  segment
);

	localparam int LAT = FRONT_STAGES + 2 + OUT_W;

	logic             acc;
	logic             f_valid;
	logic [NW-1:0]    f_n;
	logic [DW-1:0]    f_d;
	xacs_tag_t        f_tag;
	logic             q_valid;
	logic [OUT_W-1:0] q;
	xacs_tag_t        q_tag;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	xacs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (acc),
		.energy_in (energy_ev),
		.valid_out (f_valid),
		.n_out     (f_n),
		.d_out     (f_d),
		.tag_out   (f_tag)
	);

	xacs_divider #(
		.FRAC_BITS (RESULT_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (f_valid),
		.n_in      (f_n),
		.d_in      (f_d),
		.tag_in    (f_tag),
		.valid_out (q_valid),
		.q_out     (q),
		.tag_out   (q_tag)
	);

	logic             valid_s1;
	logic [OUT_W-1:0] cs_s1;
	logic             oor_s1;
	logic [SEGW-1:0]  seg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_valid;
		end
	end

	// out of range carries no usable divisor, so its quotient is dropped here
	always_ff @(posedge clk) begin
		if (q_tag.oor) begin
			cs_s1 <= '0;
		end else if (q_tag.sat) begin
			cs_s1 <= '1;
		end else begin
			cs_s1 <= q;
		end
		oor_s1 <= q_tag.oor;
		seg_s1 <= q_tag.seg;
	end

	assign valid         = valid_s1;
	assign cross_section = cs_s1;
	assign out_of_range  = oor_s1;
	assign segment       = seg_s1;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT valid)
		else $error("result strobe missing after request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(acc, LAT))
		else $error("result strobe without a request");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && out_of_range) |-> (cross_section == '0 && segment == '0))
		else $error("out-of-range result not zeroed");

	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (segment < SEGW'(SEGMENT_COUNT)))
		else $error("segment index beyond table");
`endif

endmodule
